### hw/rtl/bpc_pkg.sv
// Shared types, codes and helpers for the button press classifier.
package bpc_pkg;

  // Phase of the press classifier
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_CONFIRM = 3'd1,
    PH_HELD    = 3'd2,
    PH_GAP     = 3'd3,
    PH_HOLDOFF = 3'd4,
    PH_RELEASE = 3'd5,
    PH_QUIET   = 3'd6
  } phase_t;

  // Event codes reported per beat
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_SINGLE   = 3'd1,
    EV_DOUBLE   = 3'd2,
    EV_LONG     = 3'd3,
    EV_VERYLONG = 3'd4
  } event_t;

  // Configuration register indexes
  localparam logic [2:0] REG_DEBOUNCE  = 3'd0;
  localparam logic [2:0] REG_LONG      = 3'd1;
  localparam logic [2:0] REG_VERY_LONG = 3'd2;
  localparam logic [2:0] REG_DBL_GAP   = 3'd3;
  localparam logic [2:0] REG_HOLDOFF   = 3'd4;
  localparam logic [2:0] REG_QUIET     = 3'd5;

  // Register reset values in ticks
  localparam logic [7:0]  DEBOUNCE_RST  = 8'd3;
  localparam logic [15:0] LONG_RST      = 16'd150;
  localparam logic [15:0] VERY_LONG_RST = 16'd450;
  localparam logic [15:0] DBL_GAP_RST   = 16'd50;
  localparam logic [15:0] HOLDOFF_RST   = 16'd50;
  localparam logic [15:0] QUIET_RST     = 16'd20;

  // Saturating increments
  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    sat_inc8 = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

### hw/rtl/button_press_classifier.sv
// Button press classifier: debounces ticks of an active-low button and reports events.
//
// Usage:
//   Slave stream (s_*) takes one beat per tick; s_tdata[0] is the sampled
//   button level, 0 meaning pressed. Every accepted beat yields exactly one
//   result beat on the master stream (m_*): event code (0 none, 1 single,
//   2 double, 3 long, 4 very long) and a busy flag that is set while the
//   classifier is not idle after that tick.
//   Timing thresholds are set through the cfg_* write port (index 0..5:
//   debounce, long, very long, double gap, holdoff, quiet; other indexes
//   are dropped). Write them only while the block is idle; cfg_ready is
//   always high.
// Result timing and throughput:
//   A result appears in the cycle after its input beat is accepted; one beat
//   per cycle is sustained while m_tready is high. The whole state update is
//   one pass of logic between the state registers and the result register.
// Reset:
//   rst clears the classifier to idle, the counters to zero, the thresholds
//   to their defaults and drops any pending result.
// Stall:
//   While a result waits with m_tready low, s_tready is low; it rises again
//   in the same cycle the waiting result is taken.
module button_press_classifier
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] button_level, [7:1] zero
  // Master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [2:0] event_code, [3] busy_res, [7:4] zero
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Threshold registers
  logic [7:0]  debounce_ticks;
  logic [15:0] long_ticks;
  logic [15:0] very_long_ticks;
  logic [15:0] double_gap_ticks;
  logic [15:0] holdoff_ticks;
  logic [15:0] quiet_ticks;

  // Classifier state
  phase_t      phase, phase_next;
  logic [7:0]  filter_count, filter_count_next;
  logic [15:0] press_timer, press_timer_next;
  logic [15:0] wait_count, wait_count_next;
  event_t      event_next;

  logic in_beat;
  logic high;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_beat   = s_tvalid && s_tready;
  assign high      = s_tdata[0];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RST;
      long_ticks       <= LONG_RST;
      very_long_ticks  <= VERY_LONG_RST;
      double_gap_ticks <= DBL_GAP_RST;
      holdoff_ticks    <= HOLDOFF_RST;
      quiet_ticks      <= QUIET_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE:  debounce_ticks   <= cfg_data[7:0];
        REG_LONG:      long_ticks       <= cfg_data;
        REG_VERY_LONG: very_long_ticks  <= cfg_data;
        REG_DBL_GAP:   double_gap_ticks <= cfg_data;
        REG_HOLDOFF:   holdoff_ticks    <= cfg_data;
        REG_QUIET:     quiet_ticks      <= cfg_data;
        default: ;
      endcase
    end
  end

  // One tick of the classifier
  always_comb begin
    logic decided;
    phase_next        = phase;
    filter_count_next = filter_count;
    press_timer_next  = press_timer;
    wait_count_next   = wait_count;
    event_next        = EV_NONE;
    decided           = 1'b0;

    // Waiting phases fall through on the same tick once satisfied
    if (phase_next == PH_HOLDOFF) begin
      if (wait_count_next >= holdoff_ticks) begin
        phase_next      = PH_RELEASE;
        wait_count_next = '0;
      end else begin
        wait_count_next = sat_inc16(wait_count_next);
      end
    end
    if (phase_next == PH_RELEASE && high) begin
      phase_next      = PH_QUIET;
      wait_count_next = '0;
    end
    if (phase_next == PH_QUIET) begin
      if (wait_count_next >= quiet_ticks) begin
        phase_next      = PH_IDLE;
        wait_count_next = '0;
      end else begin
        wait_count_next = sat_inc16(wait_count_next);
      end
    end
    if (phase_next == PH_IDLE && !high) begin
      phase_next        = PH_CONFIRM;
      filter_count_next = '0;
      press_timer_next  = '0;
    end

    // Press classification
    case (phase_next)
      PH_CONFIRM: begin
        if (!high) begin
          if (filter_count_next >= debounce_ticks) begin
            filter_count_next = '0;
            phase_next        = PH_HELD;
          end
          filter_count_next = sat_inc8(filter_count_next);
        end else begin
          // glitch: rejected without an event
          decided = 1'b1;
        end
      end
      PH_HELD: begin
        if (high) begin
          if (filter_count_next >= debounce_ticks) begin
            if (press_timer_next >= long_ticks) begin
              event_next = EV_LONG;
              decided    = 1'b1;
            end else begin
              press_timer_next  = '0;
              filter_count_next = '0;
              phase_next        = PH_GAP;
            end
          end
          if (!decided) filter_count_next = sat_inc8(filter_count_next);
        end else begin
          filter_count_next = '0;
          if (press_timer_next >= very_long_ticks) begin
            event_next = EV_VERYLONG;
            decided    = 1'b1;
          end
        end
      end
      PH_GAP: begin
        // low samples count cumulatively toward a second press
        if (!high) begin
          if (filter_count_next >= debounce_ticks) begin
            event_next = EV_DOUBLE;
            decided    = 1'b1;
          end else begin
            filter_count_next = sat_inc8(filter_count_next);
          end
        end
        if (!decided && press_timer_next >= double_gap_ticks) begin
          event_next = EV_SINGLE;
          decided    = 1'b1;
        end
      end
      default: ;
    endcase

    if (phase_next == PH_CONFIRM || phase_next == PH_HELD || phase_next == PH_GAP) begin
      if (decided) begin
        phase_next        = (event_next == EV_NONE) ? PH_QUIET : PH_HOLDOFF;
        wait_count_next   = '0;
        filter_count_next = '0;
      end else begin
        press_timer_next = sat_inc16(press_timer_next);
      end
    end
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      filter_count <= '0;
      press_timer  <= '0;
      wait_count   <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (in_beat) begin
        phase        <= phase_next;
        filter_count <= filter_count_next;
        press_timer  <= press_timer_next;
        wait_count   <= wait_count_next;
      end
      if (in_beat) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      m_tdata <= {4'd0, (phase_next != PH_IDLE), event_next};
    end
  end

`ifndef SYNTHESIS
  // Every accepted beat shows up as a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> m_tvalid)
    else $error("accepted beat produced no result");

  // Any reported event leaves the classifier busy (in holdoff)
  a_event_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:0] != EV_NONE) |-> m_tdata[3])
    else $error("event reported while idle");

  // The wait counter is only used in holdoff, release and quiet
  a_wait_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE || phase == PH_CONFIRM || phase == PH_HELD || phase == PH_GAP)
      |-> (wait_count == 16'd0))
    else $error("wait counter not cleared outside waiting phases");

  // Event code stays within the defined set
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= EV_VERYLONG))
    else $error("undefined event code");
`endif

endmodule

### test/press_event_checker.sv
// Checker for the button press classifier: predicts each result beat and compares it.
`timescale 1ns / 1ps

module press_event_checker
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] button_level, [7:1] zero
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [2:0] event_code, [3] busy_res, [7:4] zero
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatch_count,
  output int          pending_events,
  output logic        busy_pred
);

  typedef struct packed {
    event_t code;
    logic   busy;
  } press_result_t;

  // Results predicted but not yet seen on the master side
  press_result_t expected_events[$];

  // Threshold copies
  logic [7:0]  thr_debounce;
  logic [15:0] thr_long;
  logic [15:0] thr_very_long;
  logic [15:0] thr_gap;
  logic [15:0] thr_holdoff;
  logic [15:0] thr_quiet;

  // Classifier state copy
  phase_t      phase;
  logic [7:0]  filt_cnt;
  logic [15:0] press_cnt;
  logic [15:0] dwell_cnt;
  int          fail_total;

  function automatic logic [7:0] up8(input logic [7:0] v);
    return (&v) ? v : v + 8'd1;
  endfunction

  function automatic logic [15:0] up16(input logic [15:0] v);
    return (&v) ? v : v + 16'd1;
  endfunction

  // Advance the classifier by one tick and return its event and busy flag
  task automatic classify_tick(input logic lvl, output event_t ev, output logic busy);
    logic decided;
    ev      = EV_NONE;
    decided = 1'b0;

    // holdoff, release wait and quiet can all run out on the same tick
    if (phase == PH_HOLDOFF) begin
      if (dwell_cnt >= thr_holdoff) begin
        phase     = PH_RELEASE;
        dwell_cnt = '0;
      end else begin
        dwell_cnt = up16(dwell_cnt);
      end
    end
    if (phase == PH_RELEASE && lvl) begin
      phase     = PH_QUIET;
      dwell_cnt = '0;
    end
    if (phase == PH_QUIET) begin
      if (dwell_cnt >= thr_quiet) begin
        phase     = PH_IDLE;
        dwell_cnt = '0;
      end else begin
        dwell_cnt = up16(dwell_cnt);
      end
    end
    if (phase == PH_IDLE && !lvl) begin
      phase     = PH_CONFIRM;
      filt_cnt  = '0;
      press_cnt = '0;
    end

    case (phase)
      PH_CONFIRM: begin
        if (!lvl) begin
          if (filt_cnt >= thr_debounce) begin
            filt_cnt = '0;
            phase    = PH_HELD;
          end
          filt_cnt = up8(filt_cnt);
        end else begin
          // glitch: released before the debounce ran out
          decided = 1'b1;
        end
      end
      PH_HELD: begin
        if (lvl) begin
          if (filt_cnt >= thr_debounce) begin
            if (press_cnt >= thr_long) begin
              ev      = EV_LONG;
              decided = 1'b1;
            end else begin
              press_cnt = '0;
              filt_cnt  = '0;
              phase     = PH_GAP;
            end
          end
          if (!decided) filt_cnt = up8(filt_cnt);
        end else begin
          filt_cnt = '0;
          if (press_cnt >= thr_very_long) begin
            ev      = EV_VERYLONG;
            decided = 1'b1;
          end
        end
      end
      PH_GAP: begin
        // low samples accumulate; a high one does not clear the count
        if (!lvl) begin
          if (filt_cnt >= thr_debounce) begin
            ev      = EV_DOUBLE;
            decided = 1'b1;
          end else begin
            filt_cnt = up8(filt_cnt);
          end
        end
        if (!decided && press_cnt >= thr_gap) begin
          ev      = EV_SINGLE;
          decided = 1'b1;
        end
      end
      default: ;
    endcase

    if (phase == PH_CONFIRM || phase == PH_HELD || phase == PH_GAP) begin
      if (decided) begin
        if (ev == EV_NONE) phase = PH_QUIET;
        else phase = PH_HOLDOFF;
        dwell_cnt = '0;
        filt_cnt  = '0;
      end else begin
        press_cnt = up16(press_cnt);
      end
    end

    busy = (phase != PH_IDLE);
  endtask

  always @(posedge clk) begin : track
    press_result_t want;
    press_result_t got;
    event_t        ev;
    logic          bsy;
    if (rst) begin
      thr_debounce  = DEBOUNCE_RST;
      thr_long      = LONG_RST;
      thr_very_long = VERY_LONG_RST;
      thr_gap       = DBL_GAP_RST;
      thr_holdoff   = HOLDOFF_RST;
      thr_quiet     = QUIET_RST;
      phase         = PH_IDLE;
      filt_cnt      = '0;
      press_cnt     = '0;
      dwell_cnt     = '0;
      fail_total    = 0;
      expected_events.delete();
      mismatch_count <= 0;
      pending_events <= 0;
      busy_pred      <= 1'b0;
    end else begin
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEBOUNCE:  thr_debounce  = cfg_data[7:0];
          REG_LONG:      thr_long      = cfg_data;
          REG_VERY_LONG: thr_very_long = cfg_data;
          REG_DBL_GAP:   thr_gap       = cfg_data;
          REG_HOLDOFF:   thr_holdoff   = cfg_data;
          REG_QUIET:     thr_quiet     = cfg_data;
          default: ;
        endcase
      end

      // result beat against the oldest prediction
      if (m_tvalid && m_tready) begin
        got.code = event_t'(m_tdata[2:0]);
        got.busy = m_tdata[3];
        if (expected_events.size() == 0) begin
          $display("%0t: result beat with no tick pending: event_code %0d busy_res %0b",
                   $time, got.code, got.busy);
          fail_total++;
        end else begin
          want = expected_events.pop_front();
          if (got.code !== want.code) begin
            $display("%0t: event_code expected %0d got %0d", $time, want.code, m_tdata[2:0]);
            fail_total++;
          end
          if (got.busy !== want.busy) begin
            $display("%0t: busy_res expected %0b got %0b", $time, want.busy, m_tdata[3]);
            fail_total++;
          end
        end
      end

      // tick beat
      if (s_tvalid && s_tready) begin
        classify_tick(s_tdata[0], ev, bsy);
        want.code = ev;
        want.busy = bsy;
        expected_events.push_back(want);
        busy_pred <= bsy;
      end

      pending_events <= expected_events.size();
      mismatch_count <= fail_total;
    end
  end

endmodule

### test/tb_button_press_classifier.sv
// Testbench top for the button press classifier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_button_press_classifier;
  import bpc_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 10;
  // indexes past the register file, which the block drops
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'd0;   // [0] button_level, [7:1] zero
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;            // [2:0] event_code, [3] busy_res, [7:4] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data  = 16'd0;

  int   mismatch_count;
  int   pending_events;
  logic busy_pred;

  int send_idle_pct = 17;
  int recv_idle_pct = 70;
  int ticks_sent    = 0;
  int stall_cycles  = 0;

  // thresholds as last written, used to shape press lengths
  int c_deb, c_long, c_vlong, c_gap, c_hold, c_quiet;

  button_press_classifier u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  press_event_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_events (pending_events),
    .busy_pred      (busy_pred)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_button_press_classifier: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one tick beat, with random sender gaps ahead of it
  task automatic send_level(input logic lvl);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, lvl};
    do @(posedge clk); while (!s_tready);
    ticks_sent++;
  endtask

  task automatic push_press(input int lows, input int highs);
    repeat (lows) send_level(1'b0);
    repeat (highs) send_level(1'b1);
  endtask

  // leaves cfg_valid high so back-to-back writes need no extra toggle
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_thresholds(input logic [15:0] deb, input logic [15:0] lng,
                                 input logic [15:0] vlng, input logic [15:0] gap,
                                 input logic [15:0] hold, input logic [15:0] quiet);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LONG, lng);
    write_reg(REG_VERY_LONG, vlng);
    write_reg(REG_DBL_GAP, gap);
    write_reg(REG_HOLDOFF, hold);
    write_reg(REG_QUIET, quiet);
    cfg_valid <= 1'b0;
    c_deb   = int'(deb[7:0]);
    c_long  = int'(lng);
    c_vlong = int'(vlng);
    c_gap   = int'(gap);
    c_hold  = int'(hold);
    c_quiet = int'(quiet);
  endtask

  task automatic load_random_small;
    load_thresholds(16'($urandom_range(0, 4)), 16'($urandom_range(0, 40)),
                    16'($urandom_range(0, 80)), 16'($urandom_range(0, 20)),
                    16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)));
  endtask

  task automatic drain_results;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_events != 0) @(posedge clk);
  endtask

  // release the button until the classifier is back to idle
  task automatic settle_idle;
    drain_results();
    while (busy_pred) begin
      send_level(1'b1);
      drain_results();
    end
  endtask

  // mostly whole presses sized around the thresholds, some bounce noise
  task automatic random_ticks(input int budget);
    int stop_at;
    int room;
    int lows;
    int highs;
    stop_at = ticks_sent + budget;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) send_level(1'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          repeat ($urandom_range(1, 3)) send_level(1'($urandom_range(0, 1)));
        end
        case ($urandom_range(0, 3))
          0: lows = $urandom_range(0, c_deb + 1);
          1: lows = c_deb + c_long + $urandom_range(0, 4);
          2: lows = c_deb + c_vlong + $urandom_range(0, 4);
          default: lows = $urandom_range(1, 2 * c_deb + 12);
        endcase
        case ($urandom_range(0, 2))
          0: highs = $urandom_range(0, c_deb + 2);
          1: highs = $urandom_range(0, c_deb + c_gap + 3);
          default: highs = c_deb + c_gap + c_hold + c_quiet + $urandom_range(2, 6);
        endcase
        room = stop_at - ticks_sent;
        if (room < 0) room = 0;
        if (lows > room) lows = room;
        if (highs > room - lows) highs = room - lows;
        push_press(lows, highs);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: glitch, single, double, long, very long with zero waits
    send_idle_pct = 17;
    recv_idle_pct = 70;
    load_thresholds(16'd1, 16'd3, 16'd5, 16'd2, 16'd0, 16'd0);
    push_press(1, 1);
    push_press(2, 4);
    push_press(2, 1);
    push_press(2, 1);
    push_press(3, 3);
    push_press(7, 1);
    settle_idle();

    load_random_small();
    random_ticks(250);
    settle_idle();

    // all thresholds at zero; spare indexes must be dropped
    send_idle_pct = 70;
    recv_idle_pct = 17;
    write_reg(REG_SPARE_A, 16'($urandom));
    write_reg(REG_SPARE_B, 16'($urandom));
    load_thresholds(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_ticks(150);
    settle_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_random_small();
    random_ticks(250);
    settle_idle();

    // every threshold at its top value; debounce keeps the low byte
    load_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_ticks(150);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_button_press_classifier: done, clean");
    end else begin
      $display("tb_button_press_classifier: done, errors");
    end
    $finish;
  end

endmodule
